### rtl/core/rcfp_pkg.sv
// Package for the radio control frame parser.
// Holds the status codes, frame constants and the step record shared by the
// check and channel modules. No dependencies.
package rcfp_pkg;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_BAD_FUNC   = 3'd2,
        ST_LEN_SHORT  = 3'd3,
        ST_TOO_LONG   = 3'd4,
        ST_CHECKSUM   = 3'd5
    } status_t;

    localparam logic [7:0] SYNC_FIRST   = 8'hAA;
    localparam logic [7:0] SYNC_SECOND  = 8'hAF;
    localparam logic [7:0] FUNC_RC      = 8'h03;
    localparam logic [7:0] MIN_DATA_LEN = 8'd12;
    localparam logic [5:0] STAGE_FIRST  = 6'd4;
    localparam logic [5:0] STAGE_END    = 6'd20;
    localparam int         STAGE_COUNT  = 16;
    localparam int         CHANNELS     = 8;

    // What the frame checker tells the channel store about the current byte.
    typedef struct packed {
        logic       take;       // a byte is consumed this cycle
        logic       last;       // that byte closes the packet
        logic       ok;         // the packet passed every check
        logic       stage_wr;   // the byte belongs to the channel area
        logic [3:0] stage_idx;  // its slot in the channel area
    } step_t;

endpackage

### rtl/core/rcfp_in_reg.sv
// Input register of the frame parser: holds one byte item until the core
// consumes it. No dependencies.
module rcfp_in_reg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       packet_end,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_end
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       load;

    // The register is free when empty or when its item moves on this cycle.
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= data_byte;
            end_reg  <= packet_end;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_end   = end_reg;

endmodule

### rtl/core/rcfp_frame_check.sv
// Frame checker: tracks position, running sum, frame length and the first
// error of the current packet, and forms the status at packet end.
// Depends on rcfp_pkg.
module rcfp_frame_check
    import rcfp_pkg::*;
#(
    parameter int PACKET_BYTES = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       last,
    output status_t    status,
    output step_t      step
);

    localparam logic [5:0] PKT_LIMIT = 6'(PACKET_BYTES);
    localparam logic [8:0] PKT_LIMIT_W = 9'(PACKET_BYTES);

    logic [5:0] pos_reg,   pos_next;
    logic [7:0] sum_reg,   sum_next;
    logic [5:0] flen_reg,  flen_next;
    status_t    err_reg,   err_next;
    logic       match_reg, match_next;

    logic       active;
    logic [6:0] pos_plus;
    logic [8:0] frame_full;
    logic [5:0] pos_off;

    assign active     = pos_reg < PKT_LIMIT;
    assign pos_plus   = {1'b0, pos_reg} + 7'd1;
    assign frame_full = {1'b0, data_byte} + 9'd5;
    assign pos_off    = pos_reg - STAGE_FIRST;

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        flen_next  = flen_reg;
        err_next   = err_reg;
        match_next = match_reg;
        if (active)
        begin
            if (err_reg == ST_OK)
            begin
                if (pos_reg == 6'd0 && data_byte != SYNC_FIRST)
                begin
                    err_next = ST_BAD_HEADER;
                end
                else if (pos_reg == 6'd1 && data_byte != SYNC_SECOND)
                begin
                    err_next = ST_BAD_HEADER;
                end
                else if (pos_reg == 6'd2 && data_byte != FUNC_RC)
                begin
                    err_next = ST_BAD_FUNC;
                end
                else if (pos_reg == 6'd3)
                begin
                    priority if (data_byte < MIN_DATA_LEN)
                    begin
                        err_next = ST_LEN_SHORT;
                    end
                    else if (frame_full > PKT_LIMIT_W)
                    begin
                        err_next = ST_TOO_LONG;
                    end
                    else
                    begin
                        flen_next = frame_full[5:0];
                    end
                end
            end

            // Header bytes always count; data bytes count only once the
            // length is known, and the byte at the length's end is the sum.
            if (pos_reg < STAGE_FIRST)
            begin
                sum_next = sum_reg + data_byte;
            end
            else if (flen_reg != 6'd0)
            begin
                if (pos_plus < {1'b0, flen_reg})
                begin
                    sum_next = sum_reg + data_byte;
                end
                else if (pos_plus == {1'b0, flen_reg})
                begin
                    match_next = (sum_reg == data_byte);
                end
            end
            pos_next = pos_plus[5:0];
        end
    end

    // Status is judged on the state that includes the closing byte. A
    // missing checksum byte reads as zero.
    always_comb
    begin
        priority if (err_next != ST_OK)
        begin
            status = err_next;
        end
        else if (pos_next < 6'd2)
        begin
            status = ST_BAD_HEADER;
        end
        else if (pos_next < 6'd3)
        begin
            status = ST_BAD_FUNC;
        end
        else if (pos_next < 6'd4 || flen_next == 6'd0)
        begin
            status = ST_LEN_SHORT;
        end
        else if (pos_next < flen_next)
        begin
            status = (sum_next == 8'd0) ? ST_OK : ST_CHECKSUM;
        end
        else
        begin
            status = match_next ? ST_OK : ST_CHECKSUM;
        end
    end

    always_comb
    begin
        step.take      = take;
        step.last      = last;
        step.ok        = (status == ST_OK);
        step.stage_wr  = active && pos_reg >= STAGE_FIRST && pos_reg < STAGE_END;
        step.stage_idx = pos_off[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            flen_reg  <= '0;
            err_reg   <= ST_OK;
            match_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                pos_reg   <= '0;
                sum_reg   <= '0;
                flen_reg  <= '0;
                err_reg   <= ST_OK;
                match_reg <= 1'b0;
            end
            else
            begin
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                flen_reg  <= flen_next;
                err_reg   <= err_next;
                match_reg <= match_next;
            end
        end
    end

endmodule

### rtl/core/rcfp_chan_store.sv
// Channel store: stages packet bytes 4 to 19 and, on a good packet end,
// latches them as eight big-endian channels. Depends on rcfp_pkg.
module rcfp_chan_store
    import rcfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  step_t       step,
    input  logic [7:0]  data_byte,
    output logic [15:0] chan [CHANNELS]
);

    logic [7:0]  stage_reg  [STAGE_COUNT];
    logic [7:0]  stage_next [STAGE_COUNT];
    logic [15:0] held_reg   [CHANNELS];

    always_comb
    begin
        for (int i = 0; i < STAGE_COUNT; i++)
        begin
            stage_next[i] = (step.stage_wr && step.stage_idx == 4'(i)) ? data_byte
                                                                       : stage_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGE_COUNT; i++)
            begin
                stage_reg[i] <= '0;
            end
            for (int c = 0; c < CHANNELS; c++)
            begin
                held_reg[c] <= '0;
            end
        end
        else if (step.take)
        begin
            for (int i = 0; i < STAGE_COUNT; i++)
            begin
                stage_reg[i] <= step.last ? 8'd0 : stage_next[i];
            end
            if (step.last && step.ok)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    held_reg[c] <= {stage_next[2 * c], stage_next[2 * c + 1]};
                end
            end
        end
    end

    assign chan = held_reg;

endmodule

### rtl/core/rc_frame_parser_top.sv
// Top level of the radio control frame parser.
// Instantiates rcfp_in_reg, rcfp_frame_check and rcfp_chan_store; uses rcfp_pkg.
//
// Usage:
//   The input channel (in_valid, in_stall, data_byte, packet_end) carries one
//   packet byte per item; packet_end marks the last byte of a packet.
//   The output channel (out_valid, out_stall, status and eight channels)
//   carries one item per packet end: the status code and the held channels,
//   which change only when a packet passes every check.
//   Throughput is one byte per cycle unless a closing byte waits on a stalled
//   receiver. A byte is checked while it sits in the input register, so a
//   result is valid in the cycle after the closing byte is taken.
//   While the receiver stalls, the result holds. Bytes that end no packet
//   keep flowing; a closing byte waits in the input register, and the
//   input stalls only then.
//   Reset clears the packet state, the staged bytes and the held channels
//   to zero and empties both registers.
module rc_frame_parser_top
    import rcfp_pkg::*;
#(
    parameter int PACKET_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        packet_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] throttle,
    output logic [15:0] yaw_channel,
    output logic [15:0] roll_channel,
    output logic [15:0] pitch_channel,
    output logic [15:0] aux_one,
    output logic [15:0] aux_two,
    output logic [15:0] aux_three,
    output logic [15:0] aux_four
);

    logic        held_valid;
    logic [7:0]  held_byte;
    logic        held_end;
    logic        out_free;
    logic        advance;
    logic        out_valid_reg, out_valid_next;
    status_t     status_reg;
    status_t     status_now;
    step_t       step;
    logic [15:0] chan [CHANNELS];

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = held_valid && (!held_end || out_free);

    rcfp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .packet_end (packet_end),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_end   (held_end)
    );

    rcfp_frame_check #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_frame_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (advance),
        .data_byte (held_byte),
        .last      (held_end),
        .status    (status_now),
        .step      (step)
    );

    rcfp_chan_store u_chan_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (held_byte),
        .chan      (chan)
    );

    always_comb
    begin
        if (advance && held_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && held_end)
        begin
            status_reg <= status_now;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign throttle      = chan[0];
    assign yaw_channel   = chan[1];
    assign roll_channel  = chan[2];
    assign pitch_channel = chan[3];
    assign aux_one       = chan[4];
    assign aux_two       = chan[5];
    assign aux_three     = chan[6];
    assign aux_four      = chan[7];

endmodule
